### sv/bmb_pkg.sv
// shared types, codes and card descriptions for the banked memory board
package bmb_pkg;

  localparam int MAX_BANKS_DEF   = 16;
  localparam int PLANE_BYTES_DEF = 65536;

  // bus opcodes
  localparam logic [2:0] OP_MEM_RD  = 3'd0;
  localparam logic [2:0] OP_MEM_WR  = 3'd1;
  localparam logic [2:0] OP_IO_WR   = 3'd2;
  localparam logic [2:0] OP_IO_RD   = 3'd3;
  localparam logic [2:0] OP_SET_PG  = 3'd4;
  localparam logic [2:0] OP_PRELOAD = 3'd5;

  // page kinds
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_RAM   = 2'd1;
  localparam logic [1:0] KIND_ROM   = 2'd2;

  // card types
  localparam logic [2:0] CARD_NONE    = 3'd0;
  localparam logic [2:0] CARD_BIN8    = 3'd1;
  localparam logic [2:0] CARD_ONEHOT8 = 3'd2;
  localparam logic [2:0] CARD_ONEHOT7 = 3'd3;
  localparam logic [2:0] CARD_BIN16   = 3'd4;
  localparam logic [2:0] CARD_BIN16B  = 3'd5;

  // phantom modes
  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_READS = 2'd1;
  localparam logic [1:0] PH_ALL   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CARD_TYPE = 2'd0;
  localparam logic [1:0] REG_HONOR_PH  = 2'd1;
  localparam logic [1:0] REG_PH_MODE   = 2'd2;

  localparam logic [7:0] ONEHOT8_IGNORE = 8'hBF;

  typedef struct packed {
    logic [7:0] port;
    logic [4:0] banks;
    logic       one_hot;
    logic [7:0] mask;
  } card_desc_t;

  function automatic card_desc_t card_desc(input logic [2:0] t);
    card_desc_t d;
    case (t)
      CARD_BIN8:    d = '{port: 8'hFF, banks: 5'd8,  one_hot: 1'b0, mask: 8'h07};
      CARD_ONEHOT8: d = '{port: 8'h40, banks: 5'd8,  one_hot: 1'b1, mask: 8'hFF};
      CARD_ONEHOT7: d = '{port: 8'h40, banks: 5'd7,  one_hot: 1'b1, mask: 8'h7F};
      CARD_BIN16:   d = '{port: 8'hC0, banks: 5'd16, one_hot: 1'b0, mask: 8'h0F};
      CARD_BIN16B:  d = '{port: 8'h40, banks: 5'd16, one_hot: 1'b0, mask: 8'h0F};
      default:      d = '{port: 8'h00, banks: 5'd1,  one_hot: 1'b0, mask: 8'hFF};
    endcase
    return d;
  endfunction

endpackage

### sv/bmb_store.sv
// byte store: one plane per bank, single port, registered read
module bmb_store #(
  parameter int DEPTH = 1048576,
  parameter int AW    = 20
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/banked_memory_board.sv
// top level of the banked memory board
// One bus cycle per item. start is taken when busy is low; the result strobe
// out_valid rises once the item has passed the ST_MOD and ST_MEM states and
// holds for one cycle; busy is low again in that strobe cycle, so a new item
// can be taken as a result is shown. The steps are the page table read, the
// reduction of the address into the plane (a multiply by the reciprocal of
// the plane size and a multiply-subtract), and the single-ported byte store
// read or write. The receiver cannot stall; results must be taken when shown.
// The page table resets to empty through per-page valid bits, so no clearing
// pass is needed. Configuration writes are always ready; writing the card
// type clears the bank latch.
module banked_memory_board #(
  parameter int MAX_BANKS   = bmb_pkg::MAX_BANKS_DEF,
  parameter int PLANE_BYTES = bmb_pkg::PLANE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_bus_data,
  input  logic        in_phantom_in,
  output logic        out_valid,
  output logic        out_answered,
  output logic [7:0]  out_read_data,
  output logic        out_phantom_out,
  output logic        out_select_rejected,
  output logic [3:0]  out_live_bank,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  import bmb_pkg::*;

  localparam int DEPTH = MAX_BANKS * PLANE_BYTES;
  localparam int SA    = $clog2(DEPTH);
  localparam int PW    = $clog2(PLANE_BYTES);
  localparam longint unsigned RECIP =
    ((64'd1 << 32) + 64'(PLANE_BYTES) - 64'd1) / 64'(PLANE_BYTES);
  localparam int RW  = $clog2(RECIP + 1);
  localparam int PRW = 16 + RW;
  localparam int QW  = PRW - 32;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_MEM  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]  card_type_r;
  logic        honor_r;
  logic [1:0]  ph_mode_r;
  logic [3:0]  latch_r;

  logic [2:0]  op_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;
  logic        ph_in_r;
  logic [PRW-1:0] prod_r;
  logic [PW-1:0]  offs_r;

  logic [1:0] kind_mem [256];
  logic [255:0] kind_vld_r;
  logic [1:0] kind_q_r;
  logic       kind_v_r;

  logic ans_r, ph_out_r, rej_r, rd_sel_r;

  logic accept;
  assign accept    = start && !busy;
  assign busy      = !(state_r == ST_IDLE || state_r == ST_OUT);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_MEM;
      ST_MEM:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = accept ? ST_MOD : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // plane offset: exact quotient from the reciprocal, then remainder
  logic [QW-1:0] quot;
  logic [16:0]   qp;
  assign quot = prod_r[PRW-1:32];
  assign qp   = 17'(32'(quot) * 32'(PLANE_BYTES));

  // cycle decode, evaluated in the store access cycle
  logic [1:0]   kind;
  logic         is_mem, is_read, asserts, off_bus, mem_ans;
  logic [2:0]   eff_t;
  card_desc_t   desc;
  logic [4:0]   bank_cnt;
  logic [7:0]   sel_v, sel_h;
  logic [3:0]   want;
  logic         want_ok, io_hit;
  logic         st_we, st_re;
  logic [SA-1:0] st_addr;
  logic [7:0]   st_q;

  function automatic logic [7:0] in_sel_mask(input logic [7:0] v, input logic [7:0] m);
    return v & m;
  endfunction

  always_comb begin
    kind    = kind_v_r ? kind_q_r : KIND_EMPTY;
    is_read = (op_r == OP_MEM_RD);
    is_mem  = is_read || (op_r == OP_MEM_WR);
    asserts = is_mem && (kind == KIND_ROM) &&
              ((ph_mode_r == PH_ALL) || ((ph_mode_r == PH_READS) && is_read));
    off_bus = ph_in_r && honor_r && !asserts;
    mem_ans = is_mem && !off_bus &&
              ((kind == KIND_RAM) || ((kind == KIND_ROM) && is_read));

    eff_t    = (card_type_r <= CARD_BIN16B) ? card_type_r : CARD_NONE;
    desc     = card_desc(eff_t);
    bank_cnt = (32'(desc.banks) > 32'(MAX_BANKS)) ? 5'(MAX_BANKS) : desc.banks;
    io_hit   = (op_r == OP_IO_WR) && (eff_t != CARD_NONE) &&
               (addr_r[7:0] == desc.port);
    sel_v    = in_sel_mask(data_r, desc.mask);
    sel_h    = (eff_t == CARD_ONEHOT8) ? (sel_v & ONEHOT8_IGNORE) : sel_v;
    want     = '0;
    want_ok  = 1'b0;
    if (!desc.one_hot) begin
      want    = sel_v[3:0];
      want_ok = ({1'b0, sel_v} < {4'd0, bank_cnt});
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (sel_h == (8'd1 << i)) begin
          want    = 4'(i);
          want_ok = ({1'b0, 4'(i)} < bank_cnt);
        end
      end
    end

    st_we   = (state_r == ST_MEM) &&
              (((op_r == OP_MEM_WR) && mem_ans) || (op_r == OP_PRELOAD));
    st_re   = (state_r == ST_MEM) && is_read && mem_ans;
    st_addr = SA'(32'(latch_r) * 32'(PLANE_BYTES)) + SA'(offs_r);
  end

  bmb_store #(
    .DEPTH(DEPTH),
    .AW   (SA)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .re   (st_re),
    .addr (st_addr),
    .wdata(data_r),
    .rdata(st_q)
  );

  // page table memory, read at accept
  always_ff @(posedge clk) begin
    if (state_r == ST_MEM && op_r == OP_SET_PG) begin
      kind_mem[addr_r[15:8]] <= data_r[1:0];
    end
    if (accept) begin
      kind_q_r <= kind_mem[in_bus_address[15:8]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_vld_r <= '0;
      kind_v_r   <= 1'b0;
    end else begin
      if (state_r == ST_MEM && op_r == OP_SET_PG) begin
        kind_vld_r[addr_r[15:8]] <= 1'b1;
      end
      if (accept) begin
        kind_v_r <= kind_vld_r[in_bus_address[15:8]];
      end
    end
  end

  // item capture and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      addr_r  <= in_bus_address;
      data_r  <= in_bus_data;
      ph_in_r <= in_phantom_in;
      prod_r  <= PRW'(in_bus_address) * PRW'(RECIP);
    end
    if (state_r == ST_MOD) begin
      offs_r <= PW'({1'b0, addr_r} - qp);
    end
    if (state_r == ST_MEM) begin
      ans_r    <= mem_ans || io_hit;
      ph_out_r <= asserts;
      rej_r    <= io_hit && !want_ok;
      rd_sel_r <= st_re;
    end
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      card_type_r <= CARD_NONE;
      honor_r     <= 1'b0;
      ph_mode_r   <= PH_NONE;
      latch_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MEM && io_hit && want_ok) begin
        latch_r <= want;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CARD_TYPE: begin
            card_type_r <= cfg_data;
            latch_r     <= '0;
          end
          REG_HONOR_PH: honor_r   <= cfg_data[0];
          REG_PH_MODE:  ph_mode_r <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid           = (state_r == ST_OUT);
  assign out_answered        = ans_r;
  assign out_read_data       = rd_sel_r ? st_q : 8'd0;
  assign out_phantom_out     = ph_out_r;
  assign out_select_rejected = rej_r;
  assign out_live_bank       = latch_r;

endmodule

### tb/memory_board_checker.sv
// checker for the banked memory board: predicts every bus cycle and compares each result
module memory_board_checker
  import bmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_bus_data,
  input  logic        in_phantom_in,
  input  logic        out_valid,
  input  logic        out_answered,
  input  logic [7:0]  out_read_data,
  input  logic        out_phantom_out,
  input  logic        out_select_rejected,
  input  logic [3:0]  out_live_bank,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  output int          pending_count,
  output int          fail_count
);

  typedef struct packed {
    logic       answered;
    logic [7:0] read_data;
    logic       phantom_out;
    logic       select_rejected;
    logic [3:0] live_bank;
  } cycle_result_t;

  cycle_result_t expected_cycles[$];

  logic [2:0] card_type;
  logic       honor_phantom;
  logic [1:0] phantom_mode;
  logic [3:0] bank_latch;
  logic [1:0] page_kind [256];
  // one 64K plane per bank, keyed by {bank, address}
  logic [7:0] plane_bytes [bit [19:0]];

  function automatic cycle_result_t predict_bus_cycle(input logic [2:0]  op,
                                                      input logic [15:0] addr,
                                                      input logic [7:0]  data,
                                                      input logic        ph_in);
    cycle_result_t r;
    logic [1:0]    kind;
    logic          is_read;
    logic          drives;
    logic [2:0]    eff;
    logic [7:0]    port;
    logic [7:0]    mask;
    logic [7:0]    v;
    logic [7:0]    h;
    logic          one_hot;
    int            banks;
    int            want;
    int            i;
    bit [19:0]     key;
    r = '0;
    key = {bank_latch, addr};
    eff = (card_type > CARD_BIN16B) ? CARD_NONE : card_type;
    case (op)
      OP_MEM_RD, OP_MEM_WR: begin
        kind = page_kind[addr[15:8]];
        is_read = (op == OP_MEM_RD);
        drives = (kind == KIND_ROM) &&
                 (phantom_mode == PH_ALL || (phantom_mode == PH_READS && is_read));
        r.phantom_out = drives;
        // another board's phantom only counts when the card is not driving it
        if (!(ph_in && honor_phantom && !drives) &&
            (kind == KIND_RAM || (kind == KIND_ROM && is_read))) begin
          r.answered = 1'b1;
          if (is_read) begin
            r.read_data = plane_bytes.exists(key) ? plane_bytes[key] : 8'h00;
          end else begin
            plane_bytes[key] = data;
          end
        end
      end
      OP_IO_WR: begin
        port = 8'h00;
        mask = 8'hFF;
        banks = 1;
        one_hot = 1'b0;
        case (eff)
          CARD_BIN8: begin
            port = 8'hFF; mask = 8'h07; banks = 8;
          end
          CARD_ONEHOT8: begin
            port = 8'h40; mask = 8'hFF; banks = 8; one_hot = 1'b1;
          end
          CARD_ONEHOT7: begin
            port = 8'h40; mask = 8'h7F; banks = 7; one_hot = 1'b1;
          end
          CARD_BIN16: begin
            port = 8'hC0; mask = 8'h0F; banks = 16;
          end
          CARD_BIN16B: begin
            port = 8'h40; mask = 8'h0F; banks = 16;
          end
          default: ;
        endcase
        if (eff != CARD_NONE && addr[7:0] == port) begin
          r.answered = 1'b1;
          v = data & mask;
          want = -1;
          if (!one_hot) begin
            want = v;
          end else begin
            h = (eff == CARD_ONEHOT8) ? (v & ONEHOT8_IGNORE) : v;
            for (i = 0; i < 8; i++) begin
              if (h == (8'h01 << i)) want = i;
            end
          end
          if (want < 0 || want >= banks) begin
            r.select_rejected = 1'b1;
          end else begin
            bank_latch = want[3:0];
          end
        end
      end
      OP_SET_PG: page_kind[addr[15:8]] = data[1:0];
      OP_PRELOAD: plane_bytes[key] = data;
      default: ;
    endcase
    r.live_bank = bank_latch;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cycle_result_t want_r;
    if (!rst_n) begin
      expected_cycles.delete();
      card_type = CARD_NONE;
      honor_phantom = 1'b0;
      phantom_mode = PH_NONE;
      bank_latch = 4'd0;
      for (int p = 0; p < 256; p++) page_kind[p] = KIND_EMPTY;
      plane_bytes.delete();
      pending_count = 0;
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_cycles.size() == 0) begin
          $error("result strobe with no bus cycle pending");
          fail_count++;
        end else begin
          want_r = expected_cycles.pop_front();
          check_field("answered", want_r.answered, out_answered);
          check_field("read_data", want_r.read_data, out_read_data);
          check_field("phantom_out", want_r.phantom_out, out_phantom_out);
          check_field("select_rejected", want_r.select_rejected, out_select_rejected);
          check_field("live_bank", want_r.live_bank, out_live_bank);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CARD_TYPE: begin
            card_type = cfg_data;
            bank_latch = 4'd0;
          end
          REG_HONOR_PH: honor_phantom = cfg_data[0];
          REG_PH_MODE:  phantom_mode = cfg_data[1:0];
          default: ;
        endcase
      end
      if (start && busy == 1'b0) begin
        expected_cycles.insert(expected_cycles.size(),
                               predict_bus_cycle(in_opcode, in_bus_address,
                                                 in_bus_data, in_phantom_in));
      end
      pending_count = expected_cycles.size();
    end
  end

endmodule

### tb/tb_banked_memory_board.sv
// testbench top for the banked memory board: bus cycle stimulus, register writes, verdict
module tb_banked_memory_board;
  import bmb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 24;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 115;

  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam logic [2:0] OP_SPARE6   = 3'd6;
  localparam logic [2:0] OP_SPARE7   = 3'd7;
  localparam logic [2:0] CARD_SPARE6 = 3'd6;
  localparam logic [2:0] CARD_SPARE7 = 3'd7;
  localparam logic [1:0] PH_SPARE    = 2'd3;
  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam logic [7:0] PORT_BIN8   = 8'hFF;
  localparam logic [7:0] PORT_SHARED = 8'h40;
  localparam logic [7:0] PORT_BIN16  = 8'hC0;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_opcode;
  logic [15:0] in_bus_address;
  logic [7:0]  in_bus_data;
  logic        in_phantom_in;
  logic        out_valid;
  logic        out_answered;
  logic [7:0]  out_read_data;
  logic        out_phantom_out;
  logic        out_select_rejected;
  logic [3:0]  out_live_bank;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [2:0]  cfg_data;

  int          pending_count;
  int          fail_count;
  int          cycle_count;
  bit          idle_enabled;
  // addresses written in every plane up front; memory reads only go here
  logic [15:0] read_pool [POOL_SIZE];

  banked_memory_board uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_bus_address      (in_bus_address),
    .in_bus_data         (in_bus_data),
    .in_phantom_in       (in_phantom_in),
    .out_valid           (out_valid),
    .out_answered        (out_answered),
    .out_read_data       (out_read_data),
    .out_phantom_out     (out_phantom_out),
    .out_select_rejected (out_select_rejected),
    .out_live_bank       (out_live_bank),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  memory_board_checker board_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_bus_address      (in_bus_address),
    .in_bus_data         (in_bus_data),
    .in_phantom_in       (in_phantom_in),
    .out_valid           (out_valid),
    .out_answered        (out_answered),
    .out_read_data       (out_read_data),
    .out_phantom_out     (out_phantom_out),
    .out_select_rejected (out_select_rejected),
    .out_live_bank       (out_live_bank),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .pending_count       (pending_count),
    .fail_count          (fail_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // entered and left at a falling edge
  task automatic bus_cycle(input logic [2:0] op, input logic [15:0] addr,
                           input logic [7:0] data, input logic ph);
    in_opcode <= op;
    in_bus_address <= addr;
    in_bus_data <= data;
    in_phantom_in <= ph;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    if (idle_enabled && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic [2:0] card, input logic honor, input logic [1:0] mode);
    logic [1:0] idx [4];
    logic [2:0] val [4];
    idx = '{REG_CARD_TYPE, REG_HONOR_PH, REG_PH_MODE, REG_SPARE};
    val = '{card, {2'($urandom), honor}, {1'($urandom), mode}, 3'($urandom)};
    settle();
    for (int k = 0; k < 4; k++) begin
      cfg_index <= idx[k];
      cfg_data <= val[k];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        ph;
    int unsigned pick;
    logic [2:0]  phase_card  [PHASES];
    logic        phase_honor [PHASES];
    logic [1:0]  phase_mode  [PHASES];
    phase_card  = '{CARD_BIN8, CARD_ONEHOT8, CARD_ONEHOT7, CARD_BIN16, CARD_BIN16B,
                    CARD_NONE, CARD_SPARE6, CARD_SPARE7, CARD_ONEHOT7, CARD_BIN16B};
    phase_honor = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_mode  = '{PH_NONE, PH_READS, PH_ALL, PH_SPARE, PH_ALL,
                    PH_READS, PH_NONE, PH_ALL, PH_SPARE, PH_READS};
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_MEM_RD;
    in_bus_address = 16'h0000;
    in_bus_data = 8'h00;
    in_phantom_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_CARD_TYPE;
    cfg_data = 3'd0;
    idle_enabled = 1'b0;
    read_pool[0] = 16'h0000;
    read_pool[1] = 16'hFFFF;
    read_pool[2] = 16'h00FF;
    read_pool[3] = 16'hFF00;
    read_pool[4] = 16'h5555;
    read_pool[5] = 16'hAAAA;
    for (int k = 6; k < POOL_SIZE; k++) read_pool[k] = 16'($urandom);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // walk all 16 banks and write the read addresses in each plane
    configure(CARD_BIN16, 1'b0, PH_NONE);
    for (int b = 0; b < 16; b++) begin
      bus_cycle(OP_IO_WR, {8'($urandom), PORT_BIN16}, {4'($urandom), 4'(b)}, 1'($urandom));
      for (int k = 0; k < POOL_SIZE; k++) begin
        bus_cycle(OP_PRELOAD, read_pool[k], 8'($urandom), 1'($urandom));
      end
    end

    // directed cycles
    bus_cycle(OP_SET_PG, 16'h0000, {6'h00, KIND_RAM}, 1'b0);
    bus_cycle(OP_SET_PG, 16'hFF00, {6'h3F, KIND_ROM}, 1'b0);
    bus_cycle(OP_SET_PG, 16'h5500, {6'h00, KIND_SPARE}, 1'b0);
    bus_cycle(OP_MEM_RD, 16'h0000, 8'h00, 1'b0);
    bus_cycle(OP_MEM_WR, 16'h0000, 8'hFF, 1'b0);
    bus_cycle(OP_MEM_RD, 16'h0000, 8'h00, 1'b0);
    bus_cycle(OP_MEM_WR, 16'hFFFF, 8'h00, 1'b0);
    bus_cycle(OP_MEM_RD, 16'hFFFF, 8'hFF, 1'b0);
    bus_cycle(OP_MEM_RD, 16'h5555, 8'h00, 1'b0);
    bus_cycle(OP_MEM_RD, 16'hAAAA, 8'h00, 1'b0);
    bus_cycle(OP_IO_RD, 16'h00C0, 8'h03, 1'b0);
    bus_cycle(OP_IO_WR, 16'h0041, 8'h03, 1'b0);
    bus_cycle(OP_IO_WR, 16'hFFC0, 8'hFF, 1'b0);
    bus_cycle(OP_MEM_RD, 16'hFF00, 8'h00, 1'b0);
    bus_cycle(OP_IO_WR, 16'h00C0, 8'hF0, 1'b0);
    bus_cycle(OP_SPARE6, 16'hFFFF, 8'hFF, 1'b1);
    bus_cycle(OP_SPARE7, 16'h0000, 8'h00, 1'b1);
    configure(CARD_ONEHOT8, 1'b1, PH_READS);
    bus_cycle(OP_IO_WR, 16'h0040, 8'hC0, 1'b0);
    bus_cycle(OP_IO_WR, 16'h0040, 8'h03, 1'b0);
    bus_cycle(OP_IO_WR, 16'h0040, 8'h40, 1'b0);
    bus_cycle(OP_MEM_RD, 16'hFFFF, 8'h00, 1'b1);
    bus_cycle(OP_MEM_WR, 16'hFF00, 8'h00, 1'b1);
    bus_cycle(OP_MEM_RD, 16'h0000, 8'h00, 1'b1);
    bus_cycle(OP_MEM_WR, 16'h0000, 8'h12, 1'b1);

    // random cycles, one register setting per phase, no gaps in the last one
    for (int phase = 0; phase < PHASES; phase++) begin
      configure(phase_card[phase], phase_honor[phase], phase_mode[phase]);
      idle_enabled = (phase < PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        addr = 16'($urandom);
        data = 8'($urandom);
        ph = ($urandom_range(0, 2) == 0);
        if (pick < 30) begin
          op = OP_MEM_RD;
          addr = read_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 48) begin
          op = OP_MEM_WR;
          if ($urandom_range(0, 1) == 0) addr = read_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 68) begin
          op = OP_IO_WR;
          case ($urandom_range(0, 3))
            0: addr[7:0] = PORT_BIN8;
            1: addr[7:0] = PORT_SHARED;
            2: addr[7:0] = PORT_BIN16;
            default: ;
          endcase
          // one-hot selects, sometimes with the ignored bit set
          if ($urandom_range(0, 1) == 0) begin
            data = 8'h01 << $urandom_range(0, 7);
            if ($urandom_range(0, 1) == 0) data[6] = 1'b1;
          end
        end else if (pick < 72) begin
          op = OP_IO_RD;
        end else if (pick < 84) begin
          op = OP_SET_PG;
          if ($urandom_range(0, 3) != 0) begin
            addr[15:8] = read_pool[$urandom_range(0, POOL_SIZE - 1)][15:8];
          end
        end else if (pick < 96) begin
          op = OP_PRELOAD;
        end else begin
          op = ($urandom_range(0, 1) == 0) ? OP_SPARE6 : OP_SPARE7;
        end
        bus_cycle(op, addr, data, ph);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
